// File: rtl/core/adsc_pkg.sv
package adsc_pkg;

  localparam int MAX_SRC_WIDTH  = 256;
  localparam int MAX_SRC_HEIGHT = 256;
  localparam int MAX_BOX        = 8;

  localparam int ONE_Q    = 65536;
  localparam int FRAC_W   = 16;
  localparam int DIM_W    = 9;
  localparam int FIELD_W  = 8;
  localparam int ADDR_W   = $clog2(MAX_SRC_WIDTH * MAX_SRC_HEIGHT);
  localparam int PIX_W    = 4 * FIELD_W;
  localparam int NUM_W    = DIM_W + FRAC_W;
  localparam int INV_W    = $clog2(MAX_BOX * ONE_Q + 1);
  localparam int PROD_W   = DIM_W + INV_W;
  localparam int COORD_W  = 32;
  localparam int INT_W    = COORD_W - FRAC_W;
  localparam int WT_W     = FRAC_W + 1;
  localparam int WSUM_W   = $clog2((MAX_BOX + 1) * (MAX_BOX + 1) * ONE_Q + 1);
  localparam int SUM_W    = WSUM_W + FIELD_W;
  localparam int DCNT_W   = $clog2(NUM_W);
  localparam int QCNT_W   = $clog2(FIELD_W);
  localparam int CFG_IDX_W = 3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_FILL_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_DST_WIDTH  = 3'd2,
    REG_DST_HEIGHT = 3'd3,
    REG_HAS_ALPHA  = 3'd4,
    REG_SMOOTH     = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    REQ_LOAD    = 1'b0,
    REQ_REQUEST = 1'b1
  } req_type_e;

  typedef struct packed {
    logic               req_type;
    logic [FIELD_W-1:0] col;
    logic [FIELD_W-1:0] row;
    logic [FIELD_W-1:0] in_red;
    logic [FIELD_W-1:0] in_green;
    logic [FIELD_W-1:0] in_blue;
    logic [FIELD_W-1:0] in_alpha;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] out_red;
    logic [FIELD_W-1:0] out_green;
    logic [FIELD_W-1:0] out_blue;
    logic [FIELD_W-1:0] out_alpha;
    logic               no_samples;
    logic               rejected;
  } out_item_t;

  typedef struct packed {
    logic [DIM_W-1:0] src_width;
    logic [DIM_W-1:0] src_height;
    logic [DIM_W-1:0] dst_width;
    logic [DIM_W-1:0] dst_height;
    logic             has_alpha;
    logic             smooth;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic pop;
  } queue_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_CHECK,
    ST_MUL_DW,
    ST_MUL_DH,
    ST_MUL_C,
    ST_MUL_R,
    ST_BOX,
    ST_SCAN,
    ST_DRAIN,
    ST_QUOT,
    ST_OUT
  } state_e;

endpackage

// File: rtl/core/adsc_queue.sv
module adsc_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  adsc_pkg::in_item_t in_data_i,
  output adsc_pkg::in_item_t item_o,
  input  adsc_pkg::queue_ctl_t ctl_i,
  output adsc_pkg::queue_ctl_t ctl_o
);

  adsc_pkg::in_item_t                    mem_q [adsc_pkg::QUEUE_DEPTH];
  logic [adsc_pkg::QPTR_W-1:0]           wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [adsc_pkg::QCNT_FILL_W-1:0]      cnt_q, cnt_d;
  logic                                  push, pop;

  assign in_ready_o = (cnt_q != adsc_pkg::QCNT_FILL_W'(adsc_pkg::QUEUE_DEPTH));
  assign push       = in_valid_i && in_ready_o;
  assign pop        = ctl_i.pop && (cnt_q != '0);
  assign item_o     = mem_q[rd_ptr_q];
  assign ctl_o.valid = (cnt_q != '0);
  assign ctl_o.pop   = pop;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == adsc_pkg::QPTR_W'(adsc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == adsc_pkg::QPTR_W'(adsc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_data_i;
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= adsc_pkg::QCNT_FILL_W'(adsc_pkg::QUEUE_DEPTH))
    else $error("queue fill count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> (cnt_q == $past(cnt_q) - 1'b1))
    else $error("queue count did not drop on pop");

  a_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == adsc_pkg::QCNT_FILL_W'(adsc_pkg::QUEUE_DEPTH)) |-> !push)
    else $error("queue written while full");

endmodule

// File: rtl/core/adsc_engine.sv
module adsc_engine (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  adsc_pkg::cfg_t        cfg_i,
  input  adsc_pkg::in_item_t    item_i,
  input  adsc_pkg::queue_ctl_t  ctl_i,
  output adsc_pkg::queue_ctl_t  ctl_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output adsc_pkg::out_item_t   out_data_o
);

  localparam int FW = adsc_pkg::FIELD_W;

  adsc_pkg::state_e state_q, state_d;

  logic [adsc_pkg::PIX_W-1:0]  store_q [adsc_pkg::MAX_SRC_WIDTH * adsc_pkg::MAX_SRC_HEIGHT];
  logic [adsc_pkg::PIX_W-1:0]  rd_data_q;
  logic                        rd_valid_q;

  logic [FW-1:0]               col_q, row_q;
  logic                        rej_q;
  logic [adsc_pkg::DIM_W-1:0]  den_q, rem_q, rem_d;
  logic [adsc_pkg::NUM_W-1:0]  num_q;
  logic [adsc_pkg::DIM_W:0]    trial;
  logic                        trial_ge;
  logic [adsc_pkg::DCNT_W-1:0] dcnt_q;
  logic [adsc_pkg::INV_W-1:0]  inv_q;
  logic [adsc_pkg::PROD_W-1:0] prod, prod_q;
  logic [adsc_pkg::DIM_W-1:0]  mul_a;
  logic [adsc_pkg::COORD_W-1:0] offx_q, offy_q, xs_q, ys_d, xe_d, ye_d;
  logic [adsc_pkg::FRAC_W-1:0] xs_frac_q, xe_frac_q, ys_frac_q, ye_frac_q;
  logic [adsc_pkg::INT_W-1:0]  x0_q, x1_q, y0_q, y1_q, x_q, y_q;
  logic [adsc_pkg::WT_W-1:0]   wx, wy, w_d, w_q;
  logic [2*adsc_pkg::WT_W-1:0] wprod;
  logic [adsc_pkg::SUM_W-1:0]  sum_q [4];
  logic [adsc_pkg::WSUM_W-1:0] wsum_q;
  logic [adsc_pkg::SUM_W-1:0]  dshift;
  logic [FW-1:0]               quo_q [4];
  logic [adsc_pkg::QCNT_W-1:0] qcnt_q;
  logic [adsc_pkg::ADDR_W-1:0] rd_addr, wr_addr;

  logic reject0, ratio_h, inv_big, in_range, issue, scan_last, out_free, mem_we, start_req;
  logic out_valid_q;
  adsc_pkg::out_item_t out_q;

  // Configuration that can never give a valid box.
  assign reject0 = (cfg_i.src_width == '0) || (cfg_i.src_height == '0) ||
                   (cfg_i.dst_width == '0) || (cfg_i.dst_height == '0) ||
                   (32'(cfg_i.src_width) > adsc_pkg::MAX_SRC_WIDTH) ||
                   (32'(cfg_i.src_height) > adsc_pkg::MAX_SRC_HEIGHT) ||
                   (cfg_i.dst_width > cfg_i.src_width) ||
                   (cfg_i.dst_height > cfg_i.src_height);
  // The smaller ratio sets the scale; compared by cross multiplication.
  assign ratio_h = (18'(cfg_i.src_width) * 18'(cfg_i.dst_height)) >
                   (18'(cfg_i.dst_width) * 18'(cfg_i.src_height));

  assign trial    = {rem_q, num_q[adsc_pkg::NUM_W-1]};
  assign trial_ge = trial >= {1'b0, den_q};
  assign rem_d    = trial_ge ? adsc_pkg::DIM_W'(trial - {1'b0, den_q})
                             : trial[adsc_pkg::DIM_W-1:0];
  assign inv_big  = 32'(num_q) > adsc_pkg::MAX_BOX * adsc_pkg::ONE_Q;

  always_comb begin
    case (state_q)
      adsc_pkg::ST_MUL_DW: mul_a = cfg_i.dst_width;
      adsc_pkg::ST_MUL_DH: mul_a = cfg_i.dst_height;
      adsc_pkg::ST_MUL_C:  mul_a = {1'b0, col_q};
      adsc_pkg::ST_MUL_R:  mul_a = {1'b0, row_q};
      default:             mul_a = '0;
    endcase
  end
  assign prod = adsc_pkg::PROD_W'(mul_a) * adsc_pkg::PROD_W'(inv_q);

  assign ys_d = offy_q + adsc_pkg::COORD_W'(prod_q);
  assign xe_d = xs_q + adsc_pkg::COORD_W'(inv_q);
  assign ye_d = ys_d + adsc_pkg::COORD_W'(inv_q);

  // Border pixels weigh their covered fraction; the first-pixel rule wins.
  always_comb begin
    if (x_q == x0_q) begin
      wx = adsc_pkg::WT_W'(adsc_pkg::ONE_Q) - adsc_pkg::WT_W'(xs_frac_q);
    end else if (x_q == x1_q) begin
      wx = (xe_frac_q == '0) ? adsc_pkg::WT_W'(adsc_pkg::ONE_Q) : adsc_pkg::WT_W'(xe_frac_q);
    end else begin
      wx = adsc_pkg::WT_W'(adsc_pkg::ONE_Q);
    end
    if (y_q == y0_q) begin
      wy = adsc_pkg::WT_W'(adsc_pkg::ONE_Q) - adsc_pkg::WT_W'(ys_frac_q);
    end else if (y_q == y1_q) begin
      wy = (ye_frac_q == '0) ? adsc_pkg::WT_W'(adsc_pkg::ONE_Q) : adsc_pkg::WT_W'(ye_frac_q);
    end else begin
      wy = adsc_pkg::WT_W'(adsc_pkg::ONE_Q);
    end
  end
  assign wprod = wx * wy;
  assign w_d   = cfg_i.smooth ? wprod[adsc_pkg::FRAC_W +: adsc_pkg::WT_W] : adsc_pkg::WT_W'(1);

  assign in_range = (x_q < adsc_pkg::INT_W'(cfg_i.src_width)) &&
                    (y_q < adsc_pkg::INT_W'(cfg_i.src_height));
  assign rd_addr  = adsc_pkg::ADDR_W'(32'(y_q) * adsc_pkg::MAX_SRC_WIDTH + 32'(x_q));
  assign wr_addr  = adsc_pkg::ADDR_W'(32'(item_i.row) * adsc_pkg::MAX_SRC_WIDTH + 32'(item_i.col));
  assign dshift   = adsc_pkg::SUM_W'(wsum_q) << qcnt_q;
  assign out_free = !out_valid_q || out_ready_i;

  // Output decode of the controller.
  always_comb begin
    ctl_o.valid = 1'b0;
    ctl_o.pop   = (state_q == adsc_pkg::ST_IDLE) && ctl_i.valid;
    start_req   = ctl_o.pop && (item_i.req_type == adsc_pkg::REQ_REQUEST);
    mem_we      = ctl_o.pop && (item_i.req_type == adsc_pkg::REQ_LOAD) &&
                  (32'(item_i.col) < adsc_pkg::MAX_SRC_WIDTH) &&
                  (32'(item_i.row) < adsc_pkg::MAX_SRC_HEIGHT);
    issue       = (state_q == adsc_pkg::ST_SCAN) && in_range;
    scan_last   = ((x_q == x1_q) && (y_q == y1_q)) || (!cfg_i.smooth && issue);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      adsc_pkg::ST_IDLE: begin
        if (start_req) begin
          state_d = reject0 ? adsc_pkg::ST_OUT : adsc_pkg::ST_DIV;
        end
      end
      adsc_pkg::ST_DIV: begin
        if (dcnt_q == '0) begin
          state_d = adsc_pkg::ST_CHECK;
        end
      end
      adsc_pkg::ST_CHECK:  state_d = inv_big ? adsc_pkg::ST_OUT : adsc_pkg::ST_MUL_DW;
      adsc_pkg::ST_MUL_DW: state_d = adsc_pkg::ST_MUL_DH;
      adsc_pkg::ST_MUL_DH: state_d = adsc_pkg::ST_MUL_C;
      adsc_pkg::ST_MUL_C:  state_d = adsc_pkg::ST_MUL_R;
      adsc_pkg::ST_MUL_R:  state_d = adsc_pkg::ST_BOX;
      adsc_pkg::ST_BOX:    state_d = adsc_pkg::ST_SCAN;
      adsc_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_d = adsc_pkg::ST_DRAIN;
        end
      end
      adsc_pkg::ST_DRAIN:  state_d = adsc_pkg::ST_QUOT;
      adsc_pkg::ST_QUOT: begin
        if (qcnt_q == '0) begin
          state_d = adsc_pkg::ST_OUT;
        end
      end
      adsc_pkg::ST_OUT: begin
        if (out_free) begin
          state_d = adsc_pkg::ST_IDLE;
        end
      end
      default: state_d = adsc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= adsc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      rd_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_valid_q <= issue;
      if ((state_q == adsc_pkg::ST_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_q[wr_addr] <= {item_i.in_alpha, item_i.in_blue, item_i.in_green, item_i.in_red};
    end
    if (issue) begin
      rd_data_q <= store_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d;
    if (rd_valid_q) begin
      for (int k = 0; k < 4; k++) begin
        sum_q[k] <= sum_q[k] + adsc_pkg::SUM_W'(rd_data_q[FW*k +: FW]) * adsc_pkg::SUM_W'(w_q);
      end
      wsum_q <= wsum_q + adsc_pkg::WSUM_W'(w_q);
    end
    case (state_q)
      adsc_pkg::ST_IDLE: begin
        col_q  <= item_i.col;
        row_q  <= item_i.row;
        rej_q  <= reject0;
        den_q  <= ratio_h ? cfg_i.dst_height : cfg_i.dst_width;
        num_q  <= {ratio_h ? cfg_i.src_height : cfg_i.src_width, adsc_pkg::FRAC_W'(0)};
        rem_q  <= '0;
        dcnt_q <= adsc_pkg::DCNT_W'(adsc_pkg::NUM_W - 1);
      end
      adsc_pkg::ST_DIV: begin
        rem_q  <= rem_d;
        num_q  <= {num_q[adsc_pkg::NUM_W-2:0], trial_ge};
        dcnt_q <= dcnt_q - 1'b1;
      end
      adsc_pkg::ST_CHECK: begin
        rej_q <= inv_big;
        inv_q <= num_q[adsc_pkg::INV_W-1:0];
      end
      adsc_pkg::ST_MUL_DW: prod_q <= prod;
      adsc_pkg::ST_MUL_DH: begin
        offx_q <= ({adsc_pkg::COORD_W'(cfg_i.src_width) << adsc_pkg::FRAC_W} -
                   adsc_pkg::COORD_W'(prod_q)) >> 1;
        prod_q <= prod;
      end
      adsc_pkg::ST_MUL_C: begin
        offy_q <= ({adsc_pkg::COORD_W'(cfg_i.src_height) << adsc_pkg::FRAC_W} -
                   adsc_pkg::COORD_W'(prod_q)) >> 1;
        prod_q <= prod;
      end
      adsc_pkg::ST_MUL_R: begin
        xs_q   <= offx_q + adsc_pkg::COORD_W'(prod_q);
        prod_q <= prod;
      end
      adsc_pkg::ST_BOX: begin
        // An end that falls on a pixel edge does not include that pixel.
        x0_q      <= xs_q[adsc_pkg::COORD_W-1:adsc_pkg::FRAC_W];
        x1_q      <= xe_d[adsc_pkg::COORD_W-1:adsc_pkg::FRAC_W] -
                     adsc_pkg::INT_W'(xe_d[adsc_pkg::FRAC_W-1:0] == '0);
        y0_q      <= ys_d[adsc_pkg::COORD_W-1:adsc_pkg::FRAC_W];
        y1_q      <= ye_d[adsc_pkg::COORD_W-1:adsc_pkg::FRAC_W] -
                     adsc_pkg::INT_W'(ye_d[adsc_pkg::FRAC_W-1:0] == '0);
        x_q       <= xs_q[adsc_pkg::COORD_W-1:adsc_pkg::FRAC_W];
        y_q       <= ys_d[adsc_pkg::COORD_W-1:adsc_pkg::FRAC_W];
        xs_frac_q <= xs_q[adsc_pkg::FRAC_W-1:0];
        xe_frac_q <= xe_d[adsc_pkg::FRAC_W-1:0];
        ys_frac_q <= ys_d[adsc_pkg::FRAC_W-1:0];
        ye_frac_q <= ye_d[adsc_pkg::FRAC_W-1:0];
        for (int k = 0; k < 4; k++) begin
          sum_q[k] <= '0;
        end
        wsum_q <= '0;
      end
      adsc_pkg::ST_SCAN: begin
        if (x_q == x1_q) begin
          x_q <= x0_q;
          y_q <= y_q + 1'b1;
        end else begin
          x_q <= x_q + 1'b1;
        end
      end
      adsc_pkg::ST_DRAIN: qcnt_q <= adsc_pkg::QCNT_W'(FW - 1);
      adsc_pkg::ST_QUOT: begin
        // One quotient bit per cycle on all four channels.
        for (int k = 0; k < 4; k++) begin
          if (sum_q[k] >= dshift) begin
            sum_q[k]         <= sum_q[k] - dshift;
            quo_q[k][qcnt_q] <= 1'b1;
          end else begin
            quo_q[k][qcnt_q] <= 1'b0;
          end
        end
        qcnt_q <= qcnt_q - 1'b1;
      end
      adsc_pkg::ST_OUT: begin
        if (out_free) begin
          if (rej_q || (wsum_q == '0)) begin
            out_q.out_red   <= '0;
            out_q.out_green <= '0;
            out_q.out_blue  <= '0;
            out_q.out_alpha <= '0;
          end else begin
            out_q.out_red   <= quo_q[0];
            out_q.out_green <= quo_q[1];
            out_q.out_blue  <= quo_q[2];
            out_q.out_alpha <= cfg_i.has_alpha ? quo_q[3] : '0;
          end
          out_q.no_samples <= !rej_q && (wsum_q == '0);
          out_q.rejected   <= rej_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_reject_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.rejected) |->
      (out_data_o.out_red == '0 && out_data_o.out_green == '0 &&
       out_data_o.out_blue == '0 && out_data_o.out_alpha == '0 && !out_data_o.no_samples))
    else $error("rejected word carries data");

  a_empty_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.no_samples) |->
      (out_data_o.out_red == '0 && out_data_o.out_green == '0 &&
       out_data_o.out_blue == '0 && out_data_o.out_alpha == '0))
    else $error("empty box word carries color");

  a_plain_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == adsc_pkg::ST_SCAN && !cfg_i.smooth && issue) |=> (state_q == adsc_pkg::ST_DRAIN))
    else $error("plain mode kept scanning after first sample");

  a_read_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_valid_q |-> (state_q == adsc_pkg::ST_SCAN || state_q == adsc_pkg::ST_DRAIN))
    else $error("store read data outside the scan");

endmodule

// File: rtl/core/area_average_image_downscaler_core.sv
// Channel | Direction | Handshake              | Word
// in      | input     | in_valid_i/in_ready_o   | adsc_pkg::in_item_t
// out     | output    | out_valid_o/out_ready_i | adsc_pkg::out_item_t
// cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// A load word is written to the store as the back end takes it. A request word
// scans its source box, up to (MAX_BOX+1)^2 pixels, through the single read
// port of the store after the bit-serial scale divider has run.
// Reset clears control state and sets config registers to one; the pixel store
// is not cleared. A two-word queue lets input words arrive while a request is
// being computed, and the output register holds a word while the sink stalls.
module area_average_image_downscaler_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  adsc_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output adsc_pkg::out_item_t                 out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [adsc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [adsc_pkg::DIM_W-1:0]          cfg_data_i
);

  adsc_pkg::cfg_t       cfg_q;
  adsc_pkg::in_item_t   item;
  adsc_pkg::queue_ctl_t q_ctl, e_ctl;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.src_width  <= adsc_pkg::DIM_W'(1);
      cfg_q.src_height <= adsc_pkg::DIM_W'(1);
      cfg_q.dst_width  <= adsc_pkg::DIM_W'(1);
      cfg_q.dst_height <= adsc_pkg::DIM_W'(1);
      cfg_q.has_alpha  <= 1'b1;
      cfg_q.smooth     <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        adsc_pkg::REG_SRC_WIDTH:  cfg_q.src_width  <= cfg_data_i;
        adsc_pkg::REG_SRC_HEIGHT: cfg_q.src_height <= cfg_data_i;
        adsc_pkg::REG_DST_WIDTH:  cfg_q.dst_width  <= cfg_data_i;
        adsc_pkg::REG_DST_HEIGHT: cfg_q.dst_height <= cfg_data_i;
        adsc_pkg::REG_HAS_ALPHA:  cfg_q.has_alpha  <= cfg_data_i[0];
        adsc_pkg::REG_SMOOTH:     cfg_q.smooth     <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  adsc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .item_o     (item),
    .ctl_i      (e_ctl),
    .ctl_o      (q_ctl)
  );

  adsc_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .item_i      (item),
    .ctl_i       (q_ctl),
    .ctl_o       (e_ctl),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
